/* hw/rtl/tlpq_pkg.sv */
// tlpq_pkg: shared types and codes for the three-level priority queue.
// No dependencies; used by tlpq_ctrl and three_level_priority_fifo_top.
package tlpq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int NUM_LEVELS         = 3;

   typedef logic [1:0] status_type;
   typedef logic [1:0] level_type;
   typedef logic       command_type;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_EMPTY   = 2'd1;
   localparam status_type ST_FULL    = 2'd2;
   localparam status_type ST_BADPRIO = 2'd3;

   localparam command_type CMD_PUSH = 1'b0;
   localparam command_type CMD_POP  = 1'b1;

   localparam level_type PRIO_NONE = 2'd0;

   localparam level_type LVL_HIGH   = 2'd0;
   localparam level_type LVL_MIDDLE = 2'd1;
   localparam level_type LVL_LOW    = 2'd2;

   // response side control, travels from the control stage to the output mux
   typedef struct packed {
      logic       strobe;
      logic       pop_hit;
      level_type  level;
      status_type status;
   } rsp_ctrl_type;

endpackage

/* hw/rtl/three_level_priority_fifo_top.sv */
// three_level_priority_fifo_top: top level of the three-level priority queue.
// Depends on tlpq_pkg, tlpq_ctrl and tlpq_level_mem.
//
// Usage:
//   Request channel: drive req_command, req_value_in and req_priority_level
//   with start high; the word is taken at a rising edge where busy is low.
//   A push (command 0) appends the value to level 1, 2 or 3; a pop
//   (command 1) returns the head of the highest non-empty level.
//   Response channel: every request gives exactly one response word on
//   rsp_value_out / rsp_status, held for one cycle and marked by rsp_strobe.
//   Status: 0 ok, 1 pop on empty (value -1), 2 push to full level dropped,
//   3 bad priority; pushes answer value 0.
//   The response passes the request register, then the pointer/memory
//   stage, before it is on the ports.
//   Throughput: one request per cycle while busy is low; each request
//   touches one level's memory port and counts only.
//   Reset: synchronous; all levels become empty and busy is high while reset
//   is asserted. Queue storage is not cleared.
//   The receiver cannot stall; responses are never held back.
module three_level_priority_fifo_top #(
   parameter int DEPTH      = tlpq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = tlpq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic signed [31:0]    req_value_in,
   input  logic [1:0]            req_priority_level,
   output logic                  rsp_strobe,
   output logic signed [31:0]    rsp_value_out,
   output logic [1:0]            rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int NL = tlpq_pkg::NUM_LEVELS;

   logic                   accept;
   logic [NL-1:0]          wr_en;
   logic [NL-1:0]          rd_en;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic [DATA_WIDTH-1:0]  wr_data;
   logic [DATA_WIDTH-1:0]  rd_data [NL];
   tlpq_pkg::rsp_ctrl_type rsp_ctrl;

   logic signed [DATA_WIDTH-1:0] head_word;
   logic signed [63:0]           head_wide;

   assign busy   = reset;
   assign accept = start && !busy;

   tlpq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .req_command        (req_command),
      .req_value_in       (req_value_in),
      .req_priority_level (req_priority_level),
      .wr_en              (wr_en),
      .rd_en              (rd_en),
      .wr_addr            (wr_addr),
      .rd_addr            (rd_addr),
      .wr_data            (wr_data),
      .rsp_ctrl           (rsp_ctrl)
   );

   for (genvar g = 0; g < NL; g++) begin : g_level
      tlpq_level_mem #(
         .DEPTH      (DEPTH),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_mem (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (rd_en[g]),
         .rd_addr (rd_addr),
         .rd_data (rd_data[g])
      );
   end

   always_comb begin
      case (rsp_ctrl.level)
         tlpq_pkg::LVL_HIGH:   head_word = rd_data[0];
         tlpq_pkg::LVL_MIDDLE: head_word = rd_data[1];
         default:              head_word = rd_data[2];
      endcase
      head_wide = 64'(head_word);
      if (rsp_ctrl.pop_hit) begin
         rsp_value_out = head_wide[31:0];
      end else if (rsp_ctrl.status == tlpq_pkg::ST_EMPTY) begin
         rsp_value_out = '1;
      end else begin
         rsp_value_out = '0;
      end
   end

   assign rsp_strobe = rsp_ctrl.strobe;
   assign rsp_status = rsp_ctrl.status;

`ifndef NO_ASSERTIONS
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      $past(start && !busy, 2) && !$past(reset, 1) |-> rsp_strobe)
      else $error("request without response two cycles later");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without a matching request");

   a_empty_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == tlpq_pkg::ST_EMPTY |-> rsp_value_out == -32'sd1)
      else $error("empty pop must answer -1");
`endif

endmodule

/* hw/rtl/tlpq_level_mem.sv */
// tlpq_level_mem: storage for one priority level, one write and one
// registered read port. No package dependencies.
module tlpq_level_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tlpq_ctrl.sv */
// tlpq_ctrl: request register, per-level head/tail pointers and counts,
// push/pop decision and response control register. Uses tlpq_pkg.
module tlpq_ctrl #(
   parameter int DEPTH      = tlpq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = tlpq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  tlpq_pkg::command_type          req_command,
   input  logic signed [31:0]             req_value_in,
   input  tlpq_pkg::level_type            req_priority_level,
   output logic [tlpq_pkg::NUM_LEVELS-1:0] wr_en,
   output logic [tlpq_pkg::NUM_LEVELS-1:0] rd_en,
   output logic [$clog2(DEPTH)-1:0]       wr_addr,
   output logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [DATA_WIDTH-1:0]          wr_data,
   output tlpq_pkg::rsp_ctrl_type         rsp_ctrl
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int NL = tlpq_pkg::NUM_LEVELS;
   localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // request register
   logic                   valid_ff;
   tlpq_pkg::command_type  cmd_ff;
   logic signed [31:0]     value_ff;
   tlpq_pkg::level_type    prio_ff;

   logic [AW-1:0] rd_ptr_ff [NL];
   logic [AW-1:0] rd_ptr_in [NL];
   logic [AW-1:0] wr_ptr_ff [NL];
   logic [AW-1:0] wr_ptr_in [NL];
   logic [CW-1:0] count_ff  [NL];
   logic [CW-1:0] count_in  [NL];

   tlpq_pkg::rsp_ctrl_type rsp_ff;
   tlpq_pkg::rsp_ctrl_type rsp_in;

   logic [NL-1:0]       nonempty;
   tlpq_pkg::level_type pop_lvl;
   tlpq_pkg::level_type push_lvl;
   tlpq_pkg::level_type op_lvl;
   logic [CW-1:0]       cur_count;
   logic [AW-1:0]       cur_wr;
   logic [AW-1:0]       cur_rd;
   logic                do_push;
   logic                do_pop;
   logic signed [63:0]  value_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         value_ff <= req_value_in;
         prio_ff  <= req_priority_level;
      end
   end

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         nonempty[i] = (count_ff[i] != '0);
      end
      if (nonempty[0]) begin
         pop_lvl = tlpq_pkg::LVL_HIGH;
      end else if (nonempty[1]) begin
         pop_lvl = tlpq_pkg::LVL_MIDDLE;
      end else begin
         pop_lvl = tlpq_pkg::LVL_LOW;
      end
      // bad priority maps to level 0 only to keep the index in range
      push_lvl = (prio_ff == tlpq_pkg::PRIO_NONE) ? tlpq_pkg::LVL_HIGH : prio_ff - 2'd1;
      op_lvl   = (cmd_ff == tlpq_pkg::CMD_POP) ? pop_lvl : push_lvl;

      cur_count = count_ff[op_lvl];
      cur_wr    = wr_ptr_ff[op_lvl];
      cur_rd    = rd_ptr_ff[op_lvl];

      do_push = valid_ff && (cmd_ff == tlpq_pkg::CMD_PUSH) &&
                (prio_ff != tlpq_pkg::PRIO_NONE) && (cur_count != FULL_COUNT);
      do_pop  = valid_ff && (cmd_ff == tlpq_pkg::CMD_POP) && (nonempty != '0);

      rsp_in.strobe  = valid_ff;
      rsp_in.pop_hit = do_pop;
      rsp_in.level   = op_lvl;
      if (cmd_ff == tlpq_pkg::CMD_POP) begin
         rsp_in.status = do_pop ? tlpq_pkg::ST_OK : tlpq_pkg::ST_EMPTY;
      end else if (prio_ff == tlpq_pkg::PRIO_NONE) begin
         rsp_in.status = tlpq_pkg::ST_BADPRIO;
      end else if (cur_count == FULL_COUNT) begin
         rsp_in.status = tlpq_pkg::ST_FULL;
      end else begin
         rsp_in.status = tlpq_pkg::ST_OK;
      end

      for (int i = 0; i < NL; i++) begin
         wr_ptr_in[i] = wr_ptr_ff[i];
         rd_ptr_in[i] = rd_ptr_ff[i];
         count_in[i]  = count_ff[i];
         wr_en[i]     = 1'b0;
         rd_en[i]     = 1'b0;
         if (op_lvl == 2'(i)) begin
            if (do_push) begin
               wr_en[i]     = 1'b1;
               wr_ptr_in[i] = (cur_wr == LAST_ADDR) ? '0 : cur_wr + 1'b1;
               count_in[i]  = cur_count + 1'b1;
            end
            if (do_pop) begin
               rd_en[i]     = 1'b1;
               rd_ptr_in[i] = (cur_rd == LAST_ADDR) ? '0 : cur_rd + 1'b1;
               count_in[i]  = cur_count - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NL; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
         rsp_ff <= '0;
      end else begin
         for (int i = 0; i < NL; i++) begin
            rd_ptr_ff[i] <= rd_ptr_in[i];
            wr_ptr_ff[i] <= wr_ptr_in[i];
            count_ff[i]  <= count_in[i];
         end
         rsp_ff <= rsp_in;
      end
   end

   // wider data widths take the sign-extended word
   assign value_wide = 64'(value_ff);
   assign wr_data    = value_wide[DATA_WIDTH-1:0];
   assign wr_addr    = cur_wr;
   assign rd_addr    = cur_rd;
   assign rsp_ctrl   = rsp_ff;

endmodule
